// ===== rtl/core/osks_pkg.sv =====
// Package for the order statistic key set: widths, command codes, controller
// states and the control word shared by the key cells. No dependencies.
`default_nettype none
package osks_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CNT_OUT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_UPD  = 2'd2
  } state_e;

  // Control word broadcast along the chain of key cells.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/osks_key_cell.sv =====
// One key cell of the sorted chain: holds a key and its compare flags, and
// shifts with its neighbours on insert and delete. Depends on osks_pkg.
`default_nettype none
module osks_key_cell (
  input  wire                               clk_i,
  input  wire osks_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic signed [osks_pkg::KEY_W-1:0] cmd_key_i,
  input  wire logic                         occupied_i,
  input  wire logic signed [osks_pkg::KEY_W-1:0] left_key_i,
  input  wire logic                         left_lt_i,
  input  wire logic signed [osks_pkg::KEY_W-1:0] right_key_i,
  output logic signed [osks_pkg::KEY_W-1:0] key_o,
  output logic                              lt_o,
  output logic                              eq_o
);
  import osks_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    lt_q, eq_q;

  // Cells at or beyond the insertion point move one place up; on delete
  // they take the key of the neighbour above.
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en && !lt_q) begin
      key_d = left_lt_i ? cmd_key_i : left_key_i;
    end else if (ctrl_i.del_en && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctrl_i.cmp_en) begin
      lt_q <= occupied_i && (key_q < cmd_key_i);
      eq_q <= occupied_i && (key_q == cmd_key_i);
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule
`default_nettype wire

// ===== rtl/core/osks_rank_enc.sv =====
// Turns the one-hot match vector of the key cells into the matching cell's
// position and a found flag. Depends on osks_pkg for the default size.
`default_nettype none
module osks_rank_enc #(
  parameter int unsigned CAPACITY = osks_pkg::CAPACITY_DEF,
  parameter int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic [CAPACITY-1:0] eq_i,
  output logic                     found_o,
  output logic [IDX_W-1:0]         idx_o
);
  import osks_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      if (eq_i[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

  assign found_o = |eq_i;

endmodule
`default_nettype wire

// ===== rtl/core/order_statistic_key_set.sv =====
// Top level of the order statistic key set: controller, chain of key cells
// and rank encoder. Depends on osks_pkg, osks_key_cell and osks_rank_enc.
`default_nettype none
// The block keeps up to CAPACITY distinct signed 32-bit keys in ascending
// order, one key per cell of a chain. A word on the input channel carries a
// command (insert, delete or rank query) and a key. Every command passes
// through the cycle of acceptance, a compare step in which every cell checks
// its key against the command key, and an update step in which cells shift
// one place along the chain for an insert or a delete and the match vector
// is encoded into a position. The next word is accepted in the cycle after
// the update, so a new command is taken only once the previous one has
// left the compare and update steps of the controller. Only a rank query
// yields an output word: found is high when the key is stored, and
// smaller_count gives the number of stored keys below it (its 1-based rank
// minus one), or zero when the key is absent. Positions beyond seven bits
// are reported modulo 128. A query whose result finds the output register
// still occupied waits in the update step until that word is taken. An
// insert of a key already present, an insert into a full store, a delete of
// an absent key and the unused command code leave the set as it is.
module order_statistic_key_set #(
  parameter int unsigned CAPACITY = osks_pkg::CAPACITY_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [osks_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic signed [osks_pkg::KEY_W-1:0] key_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic [osks_pkg::CNT_OUT_W-1:0]    smaller_count_o
);
  import osks_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e                  state_q, state_d;
  logic [CMD_W-1:0]        cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  logic                    found_q;
  logic [CNT_OUT_W-1:0]    smaller_q;
  logic                    load_out;

  cell_ctrl_t              ctrl;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     occupied;

  logic                    present;
  logic [IDX_W-1:0]        match_idx;
  logic [CNT_OUT_W-1:0]    match_cnt;
  logic                    full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign full       = (count_q == CNT_W'(CAPACITY));

  // The chain of key cells. Cell zero sees the command key on its left, and
  // the last cell sees its own key on its right.
  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic                    left_lt;
    logic signed [KEY_W-1:0] right_key;

    if (g == 0) begin : g_first
      assign left_key = key_q;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[g-1];
      assign left_lt  = cell_lt[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    assign occupied[g] = (count_q > CNT_W'(g));

    osks_key_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cmd_key_i  (key_q),
      .occupied_i (occupied[g]),
      .left_key_i (left_key),
      .left_lt_i  (left_lt),
      .right_key_i(right_key),
      .key_o      (cell_key[g]),
      .lt_o       (cell_lt[g]),
      .eq_o       (cell_eq[g])
    );
  end

  osks_rank_enc #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W)
  ) u_enc (
    .eq_i   (cell_eq),
    .found_o(present),
    .idx_o  (match_idx)
  );

  // Positions wider than the output field are reported in their low bits.
  if (IDX_W >= CNT_OUT_W) begin : g_trunc
    assign match_cnt = match_idx[CNT_OUT_W-1:0];
  end else begin : g_ext
    assign match_cnt = {{(CNT_OUT_W - IDX_W){1'b0}}, match_idx};
  end

  // Controller: compare, then update; a query leaves the update step only
  // once the output register is free to take its result.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ctrl        = '0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        case (cmd_q)
          CMD_INSERT: begin
            state_d = ST_IDLE;
            if (!present && !full) begin
              ctrl.ins_en = 1'b1;
              count_d     = count_q + CNT_W'(1);
            end
          end
          CMD_DELETE: begin
            state_d = ST_IDLE;
            if (present) begin
              ctrl.del_en = 1'b1;
              count_d     = count_q - CNT_W'(1);
            end
          end
          CMD_QUERY: begin
            if (!out_valid_q || out_ready_i) begin
              load_out    = 1'b1;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
    end
    if (load_out) begin
      found_q   <= present;
      smaller_q <= present ? match_cnt : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign smaller_count_o = smaller_q;

  // The fill count never passes the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("key count exceeds capacity");

  // Stored keys are distinct, so at most one cell matches the command key.
  a_single_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $onehot0(cell_eq))
    else $error("more than one cell matches the key");

  // The fill count moves only in the update step.
  a_count_steady : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_UPD) |=> $stable(count_q))
    else $error("key count changed outside the update step");

  // An absent key reports a zero count.
  a_absent_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (smaller_count_o == '0))
    else $error("absent key with non-zero count");

endmodule
`default_nettype wire

// ===== tb/sv/order_statistic_key_set_tb.sv =====
// Self-checking testbench for order_statistic_key_set: drives insert, delete
// and rank query words and checks every answer against a sorted key list.
// Depends on osks_pkg and the order_statistic_key_set RTL.
`default_nettype none
module order_statistic_key_set_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import osks_pkg::*;

  localparam int unsigned STORE_DEPTH = CAPACITY_DEF;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles to let pass once the last answer has arrived.
  localparam int unsigned SETTLE_CYCLES = 20;
  // Idling stops once this few words are still waiting to be sent.
  localparam int unsigned CALM_TAIL = 200;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // One command word waiting to be sent. When hold_for_drain is set the
  // sender keeps quiet until every outstanding answer has been returned.
  typedef struct {
    cmd_e                     cmd;
    logic signed [KEY_W-1:0]  key;
    bit                       hold_for_drain;
  } command_word_t;

  // What a rank query is expected to return.
  typedef struct {
    logic                     found;
    logic [CNT_OUT_W-1:0]     smaller_count;
  } rank_answer_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         cmd_i           = CMD_NONE;
  logic signed [KEY_W-1:0]  key_i           = '0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic                     found_o;
  logic [CNT_OUT_W-1:0]     smaller_count_o;

  command_word_t              pending_words[$];
  rank_answer_t               expected_answers[$];
  // Shadow copy of the stored keys, kept in ascending signed order.
  logic signed [KEY_W-1:0]    key_set[$];
  logic signed [KEY_W-1:0]    key_pool[96];

  int unsigned words_taken;
  int unsigned answers_seen;
  int unsigned error_count;
  int unsigned send_gap_left;
  int unsigned take_stall_left;
  int unsigned quiet_cycles;

  order_statistic_key_set dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .smaller_count_o (smaller_count_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one accepted command word to the shadow key list. The position
  // of a key is the number of stored keys below it; a rank query pushes the
  // answer the block has to give, with the count cut to the output width.
  function automatic void track_command(cmd_e op, logic signed [KEY_W-1:0] k);
    int           below;
    bit           hit;
    rank_answer_t ans;
    below = 0;
    foreach (key_set[i]) begin
      if (key_set[i] < k) below++;
    end
    hit = (below < key_set.size()) && (key_set[below] == k);
    case (op)
      CMD_INSERT: begin
        // Duplicates and inserts into a full store leave the set alone.
        if (!hit && key_set.size() < STORE_DEPTH) key_set.insert(below, k);
      end
      CMD_DELETE: begin
        if (hit) key_set.delete(below);
      end
      CMD_QUERY: begin
        ans.found         = hit;
        ans.smaller_count = hit ? CNT_OUT_W'(below) : '0;
        expected_answers.push_back(ans);
      end
      default: begin
        // The unused code changes nothing and returns nothing.
      end
    endcase
  endfunction

  function automatic void add_word(cmd_e op, logic signed [KEY_W-1:0] k,
                                   bit hold = 1'b0);
    command_word_t w;
    w.cmd            = op;
    w.key            = k;
    w.hold_for_drain = hold;
    pending_words.push_back(w);
  endfunction

  // Most keys come from a small pool so that inserts, deletes and queries
  // keep meeting each other; the rest are fully random 32-bit values.
  function automatic logic signed [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, 95)];
  endfunction

  // The pool mixes three kinds of key: small values close to zero, keys
  // hugging both ends of the signed range, and unrestricted ones.
  function automatic void refill_pool();
    for (int i = 0; i < 32; i++) begin
      key_pool[i]      = $signed($urandom_range(0, 100)) - 50;
      key_pool[32 + i] = (i % 2 == 0) ? KEY_MIN + $urandom_range(0, 15)
                                      : KEY_MAX - $urandom_range(0, 15);
      key_pool[64 + i] = $urandom;
    end
  endfunction

  // Idling is switched off in stretches, and for the whole tail of the run.
  function automatic bit send_idling_on();
    return pending_words.size() > CALM_TAIL && (words_taken / 150) % 3 != 2;
  endfunction

  function automatic bit take_idling_on();
    return pending_words.size() > CALM_TAIL && (answers_seen / 40) % 3 != 2;
  endfunction

  // Stimulus generation, reset and the end of the run.
  initial begin
    int unsigned phase;
    int unsigned roll;
    int unsigned insert_pct[4];
    int unsigned delete_pct[4];
    cmd_e        op;

    // Phases: filling, balanced, draining, and filling hard against the
    // capacity limit so that inserts into a full store are seen.
    insert_pct = '{60, 30, 10, 75};
    delete_pct = '{10, 30, 55, 5};

    // Directed opening: the empty store, both ends of the key range,
    // duplicates, absent keys and the unused command code.
    add_word(CMD_QUERY,  32'sd0);
    add_word(CMD_DELETE, 32'sd5);
    add_word(CMD_INSERT, KEY_MIN);
    add_word(CMD_INSERT, KEY_MAX);
    add_word(CMD_INSERT, 32'sd0);
    add_word(CMD_INSERT, -32'sd1);
    add_word(CMD_INSERT, 32'sd0);
    add_word(CMD_QUERY,  KEY_MIN);
    add_word(CMD_QUERY,  KEY_MAX);
    add_word(CMD_QUERY,  -32'sd1);
    add_word(CMD_QUERY,  32'sd1);
    add_word(CMD_NONE,   KEY_MAX);
    add_word(CMD_DELETE, 32'sd0);
    add_word(CMD_QUERY,  KEY_MAX);
    add_word(CMD_DELETE, 32'sd0);
    add_word(CMD_INSERT, 32'sh5555_5555);
    add_word(CMD_INSERT, 32'shAAAA_AAAA);
    add_word(CMD_QUERY,  32'sh5555_5555);
    add_word(CMD_QUERY,  32'shAAAA_AAAA);
    add_word(CMD_DELETE, KEY_MIN);
    add_word(CMD_DELETE, KEY_MAX);
    add_word(CMD_QUERY,  -32'sd1);

    // Random part in phases of 200 words, with the key pool renewed every
    // other phase. Twice the sender waits for every answer to come back.
    for (int n = 0; n < 1600; n++) begin
      phase = (n / 200) % 4;
      if (n % 400 == 0) refill_pool();
      roll = $urandom_range(0, 99);
      if (roll >= 98)                                  op = CMD_NONE;
      else if (roll < insert_pct[phase])               op = CMD_INSERT;
      else if (roll < insert_pct[phase] + delete_pct[phase]) op = CMD_DELETE;
      else                                             op = CMD_QUERY;
      add_word(op, pool_key(), n == 0 || n == 800);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampling on the falling edge keeps these checks clear of the updates
    // made at the rising edge.
    while (pending_words.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_answers.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (error_count == 0) begin
      $display("order_statistic_key_set verification clean");
    end else begin
      $display("order_statistic_key_set verification failed");
    end
    $finish;
  end

  // Sender: offers the oldest pending word, holding it until it is taken,
  // and feeds every accepted word to the shadow model.
  always @(posedge clk_i or negedge rst_ni) begin
    command_word_t w;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      cmd_i         <= CMD_NONE;
      key_i         <= '0;
      send_gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        track_command(cmd_e'(cmd_i), key_i);
        words_taken++;
      end
      // A word that is still on offer and not yet taken stays as it is.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap_left > 0) begin
          send_gap_left <= send_gap_left - 1;
          in_valid_i    <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_words[0].hold_for_drain && expected_answers.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (send_idling_on() && $urandom_range(0, 4) == 0) begin
          send_gap_left <= $urandom_range(0, 2);
          in_valid_i    <= 1'b0;
        end else begin
          w          = pending_words.pop_front();
          cmd_i      <= w.cmd;
          key_i      <= w.key;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks every answer taken against the oldest expectation and
  // drops ready in short random bursts, whether or not a word is waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    rank_answer_t want;
    if (!rst_ni) begin
      out_ready_i     <= 1'b0;
      take_stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          error_count++;
          $display("%0t: answer with none expected: found=%0b smaller_count=%0d",
                   $time, found_o, smaller_count_o);
        end else begin
          want = expected_answers.pop_front();
          if (found_o !== want.found) begin
            error_count++;
            $display("%0t: found expected %0b actual %0b",
                     $time, want.found, found_o);
          end
          if (smaller_count_o !== want.smaller_count) begin
            error_count++;
            $display("%0t: smaller_count expected %0d actual %0d",
                     $time, want.smaller_count, smaller_count_o);
          end
        end
      end
      if (take_stall_left > 0) begin
        take_stall_left <= take_stall_left - 1;
        out_ready_i     <= 1'b0;
      end else if (take_idling_on() && $urandom_range(0, 3) == 0) begin
        take_stall_left <= $urandom_range(0, 2);
        out_ready_i     <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which no word moves for too long has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("order_statistic_key_set verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
`default_nettype wire
